### hw/rtl/size_based_credit_calibrator_core_assert.svh
// ---------------------------------------------------------------------------
// Credit calibrator assertion macros
// Shorthand for the concurrent checks used by the calibrator RTL.
// ---------------------------------------------------------------------------
`ifndef SIZE_BASED_CREDIT_CALIBRATOR_CORE_ASSERT_SVH
`define SIZE_BASED_CREDIT_CALIBRATOR_CORE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SBCC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SBCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/sbcc_pkg.sv
// ---------------------------------------------------------------------------
// Credit calibrator package
// Shared widths, register indexes, request codes, divider control type and clamp helpers.
// ---------------------------------------------------------------------------
package sbcc_pkg;

    localparam int DIVIDEND_W = 64;
    localparam int DIVISOR_W  = 31;
    localparam int CNT_W      = $clog2(DIVIDEND_W + 1);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam int WARMUP_SAMPLES_DEF = 10;

    localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;

    localparam logic [CFG_IDX_W-1:0] REG_BUFFER_CAPACITY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_BATCH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_INTERVAL     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_FACTOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEADY_RATE      = 3'd4;

    localparam logic [1:0] REQ_BATCH     = 2'd0;
    localparam logic [1:0] REQ_CALIBRATE = 2'd1;
    localparam logic [1:0] REQ_QUERY     = 2'd2;

    typedef struct packed {
        logic start;
        logic wide;
    } div_ctl_t;

    function automatic logic [30:0] clamp31(input logic [63:0] x);
        logic [30:0] r;
        if (x == 64'd0) begin
            r = 31'd1;
        end else if (x > {33'd0, MAX31}) begin
            r = MAX31;
        end else begin
            r = x[30:0];
        end
        return r;
    endfunction

    function automatic logic [15:0] nonzero16(input logic [15:0] x);
        return (x == 16'd0) ? 16'd1 : x;
    endfunction

    function automatic logic [30:0] nonzero31(input logic [30:0] x);
        return (x == 31'd0) ? 31'd1 : x;
    endfunction

endpackage

### hw/rtl/sbcc_div.sv
// ---------------------------------------------------------------------------
// Shared iterative divider
// Restoring divider that retires one quotient bit per cycle, over either a
// full 64-bit dividend or a short 31-bit dividend.
// ---------------------------------------------------------------------------
`include "size_based_credit_calibrator_core_assert.svh"

module sbcc_div
    import sbcc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  div_ctl_t              ctl,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic                  done
);

    localparam int SHORT_PAD = DIVIDEND_W - DIVISOR_W;

    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  div_reg, div_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;

    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign ge    = trial >= {1'b0, div_reg};
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            rem_next  = '0;
            div_next  = divisor;
            busy_next = 1'b1;
            if (ctl.wide)
            begin
                quo_next = dividend;
                cnt_next = CNT_W'(DIVIDEND_W);
            end
            else
            begin
                quo_next = {dividend[DIVISOR_W-1:0], {SHORT_PAD{1'b0}}};
                cnt_next = CNT_W'(DIVISOR_W);
            end
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

    `SBCC_ASSERT_NEXT(a_div_finish, clk, rst_n, busy_reg && !ctl.start && cnt_reg == CNT_W'(1), done_reg && !busy_reg, "divider did not finish on its last step")
    `SBCC_ASSERT_NEXT(a_div_start, clk, rst_n, ctl.start, busy_reg && !done_reg, "divider did not start")
    `SBCC_ASSERT_SAME(a_div_done_idle, clk, rst_n, done_reg, !busy_reg, "divider done while still busy")

endmodule

### hw/rtl/size_based_credit_calibrator_core.sv
// ---------------------------------------------------------------------------
// Size-based credit calibrator
// Samples batch sizes, estimates bytes per element and answers calibration
// and initial-query requests with buffer credit, batch size and the count to
// the next calibration.
// ---------------------------------------------------------------------------
// A batch request is absorbed directly in the idle state. Initial queries and
// calibrate requests run on the shared divider, which retires one quotient bit
// per cycle: 64 steps for the total (calibrate only), then 31 for the credit
// and, for a calibrate request, 31 for the batch-size quotient. The block takes
// no new request while a query or calibration is in progress or its result waits
// for the output register; a result held there does not hold up input.
`include "size_based_credit_calibrator_core_assert.svh"

module size_based_credit_calibrator_core
    import sbcc_pkg::*;
#(
    parameter int WARMUP_SAMPLES = WARMUP_SAMPLES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            req_type,
    input  logic [31:0]           batch_bytes,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [30:0]           max_credit,
    output logic [30:0]           batch_size,
    output logic [30:0]           next_calibration
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_TOT_GO   = 4'd1;
    localparam logic [3:0] S_TOT_WAIT = 4'd2;
    localparam logic [3:0] S_MIX_A    = 4'd3;
    localparam logic [3:0] S_MIX_B    = 4'd4;
    localparam logic [3:0] S_CAP_GO   = 4'd5;
    localparam logic [3:0] S_CAP_WAIT = 4'd6;
    localparam logic [3:0] S_BPB_GO   = 4'd7;
    localparam logic [3:0] S_BPB_WAIT = 4'd8;
    localparam logic [3:0] S_NEXT     = 4'd9;
    localparam logic [3:0] S_DONE     = 4'd10;

    localparam logic [30:0] WARMUP_DIV  = 31'(WARMUP_SAMPLES);
    localparam logic [8:0]  WEIGHT_ONE  = 9'd256;

    logic [30:0] cap_reg, bpb_reg;
    logic [15:0] interval_reg, steady_reg;
    logic [8:0]  smooth_reg;

    logic [15:0] sample_count_reg, sample_count_next;
    logic [15:0] sample_rate_reg, sample_rate_next;
    logic [63:0] total_reg, total_next;
    logic [30:0] eb_reg, eb_next;
    logic        warm_reg, warm_next;

    logic [3:0]  state_reg, state_next;
    logic        query_reg, query_next;
    logic [30:0] m_reg, m_next;
    logic [39:0] mix_reg, mix_next;
    logic [30:0] res_mc_reg, res_mc_next;
    logic [30:0] res_bs_reg, res_bs_next;
    logic [30:0] res_nc_reg, res_nc_next;

    logic        out_valid_reg, out_valid_next;
    logic [30:0] out_mc_reg, out_mc_next;
    logic [30:0] out_bs_reg, out_bs_next;
    logic [30:0] out_nc_reg, out_nc_next;

    div_ctl_t    div_ctl;
    logic [63:0] div_dividend;
    logic [30:0] div_divisor;
    logic [63:0] div_quo;
    logic        div_done;

    logic        in_fire;
    logic [15:0] count_inc;
    logic [64:0] total_sum;
    logic [8:0]  weight;
    logic [8:0]  weight_old;
    logic [39:0] mix_sum;
    logic [31:0] next_prod;

    assign in_ready   = (state_reg == S_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign count_inc  = sample_count_reg + 16'd1;
    assign total_sum  = {1'b0, total_reg} + {33'd0, batch_bytes};
    assign weight     = (smooth_reg > WEIGHT_ONE) ? WEIGHT_ONE : smooth_reg;
    assign weight_old = WEIGHT_ONE - weight;
    assign mix_sum    = mix_reg + ({31'd0, weight_old} * {9'd0, eb_reg});
    assign next_prod  = {16'd0, sample_rate_reg} * {16'd0, nonzero16(interval_reg)};

    always_comb
    begin
        div_ctl.start = (state_reg == S_TOT_GO) || (state_reg == S_CAP_GO)
                        || (state_reg == S_BPB_GO);
        div_ctl.wide  = (state_reg == S_TOT_GO);
        case (state_reg)
            S_TOT_GO:
            begin
                div_dividend = total_reg;
                div_divisor  = warm_reg ? WARMUP_DIV : {15'd0, nonzero16(interval_reg)};
            end
            S_CAP_GO:
            begin
                div_dividend = {33'd0, cap_reg};
                div_divisor  = query_reg ? nonzero31(bpb_reg) : eb_reg;
            end
            default:
            begin
                div_dividend = {33'd0, bpb_reg};
                div_divisor  = eb_reg;
            end
        endcase
    end

    sbcc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .done     (div_done)
    );

    always_comb
    begin
        sample_count_next = sample_count_reg;
        sample_rate_next  = sample_rate_reg;
        total_next        = total_reg;
        eb_next           = eb_reg;
        warm_next         = warm_reg;
        state_next        = state_reg;
        query_next        = query_reg;
        m_next            = m_reg;
        mix_next          = mix_reg;
        res_mc_next       = res_mc_reg;
        res_bs_next       = res_bs_reg;
        res_nc_next       = res_nc_reg;
        out_valid_next    = out_valid_reg;
        out_mc_next       = out_mc_reg;
        out_bs_next       = out_bs_reg;
        out_nc_next       = out_nc_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (req_type)
                        REQ_BATCH:
                        begin
                            sample_count_next = count_inc;
                            if (count_inc == sample_rate_reg)
                            begin
                                sample_count_next = 16'd0;
                                total_next = total_sum[64] ? {64{1'b1}} : total_sum[63:0];
                            end
                        end
                        REQ_CALIBRATE:
                        begin
                            query_next = 1'b0;
                            state_next = S_TOT_GO;
                        end
                        REQ_QUERY:
                        begin
                            query_next = 1'b1;
                            state_next = S_CAP_GO;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_TOT_GO:
            begin
                state_next = S_TOT_WAIT;
            end
            S_TOT_WAIT:
            begin
                if (div_done)
                begin
                    if (warm_reg)
                    begin
                        eb_next          = clamp31(div_quo);
                        warm_next        = 1'b0;
                        sample_rate_next = nonzero16(steady_reg);
                        total_next       = 64'd0;
                        state_next       = S_CAP_GO;
                    end
                    else
                    begin
                        m_next     = clamp31(div_quo);
                        state_next = S_MIX_A;
                    end
                end
            end
            S_MIX_A:
            begin
                mix_next   = {31'd0, weight} * {9'd0, m_reg};
                state_next = S_MIX_B;
            end
            S_MIX_B:
            begin
                eb_next    = clamp31({32'd0, mix_sum[39:8]});
                total_next = 64'd0;
                state_next = S_CAP_GO;
            end
            S_CAP_GO:
            begin
                state_next = S_CAP_WAIT;
            end
            S_CAP_WAIT:
            begin
                if (div_done)
                begin
                    res_mc_next = clamp31(div_quo);
                    if (query_reg)
                    begin
                        res_bs_next = 31'd1;
                        res_nc_next = WARMUP_DIV;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_BPB_GO;
                    end
                end
            end
            S_BPB_GO:
            begin
                state_next = S_BPB_WAIT;
            end
            S_BPB_WAIT:
            begin
                if (div_done)
                begin
                    res_bs_next = clamp31(div_quo);
                    state_next  = S_NEXT;
                end
            end
            S_NEXT:
            begin
                res_nc_next = next_prod[31] ? MAX31 : next_prod[30:0];
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_mc_next    = res_mc_reg;
                    out_bs_next    = res_bs_reg;
                    out_nc_next    = res_nc_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg      <= 31'd65536;
            bpb_reg      <= 31'd2048;
            interval_reg <= 16'd20;
            smooth_reg   <= 9'd64;
            steady_reg   <= 16'd50;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_BUFFER_CAPACITY:  cap_reg      <= cfg_data;
                REG_BYTES_PER_BATCH:  bpb_reg      <= cfg_data;
                REG_CAL_INTERVAL:     interval_reg <= cfg_data[15:0];
                REG_SMOOTHING_FACTOR: smooth_reg   <= cfg_data[8:0];
                REG_STEADY_RATE:      steady_reg   <= cfg_data[15:0];
                default:              cap_reg      <= cap_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= 16'd0;
            sample_rate_reg  <= 16'd1;
            total_reg        <= 64'd0;
            eb_reg           <= 31'd1;
            warm_reg         <= 1'b1;
            state_reg        <= S_IDLE;
            query_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            sample_count_reg <= sample_count_next;
            sample_rate_reg  <= sample_rate_next;
            total_reg        <= total_next;
            eb_reg           <= eb_next;
            warm_reg         <= warm_next;
            state_reg        <= state_next;
            query_reg        <= query_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg      <= m_next;
        mix_reg    <= mix_next;
        res_mc_reg <= res_mc_next;
        res_bs_reg <= res_bs_next;
        res_nc_reg <= res_nc_next;
        out_mc_reg <= out_mc_next;
        out_bs_reg <= out_bs_next;
        out_nc_reg <= out_nc_next;
    end

    assign out_valid        = out_valid_reg;
    assign max_credit       = out_mc_reg;
    assign batch_size       = out_bs_reg;
    assign next_calibration = out_nc_reg;

    `SBCC_ASSERT_SAME(a_done_in_wait, clk, rst_n, div_done, state_reg == S_TOT_WAIT || state_reg == S_CAP_WAIT || state_reg == S_BPB_WAIT, "divider result arrived outside a wait state")
    `SBCC_ASSERT_NEXT(a_cal_start, clk, rst_n, in_fire && req_type == REQ_CALIBRATE, state_reg == S_TOT_GO, "calibrate request did not start the total division")
    `SBCC_ASSERT_SAME(a_result_source, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == S_DONE, "result presented without a finished request")
    `SBCC_ASSERT_NEXT(a_warm_once, clk, rst_n, !warm_reg, !warm_reg, "warm-up flag set again after first calibration")

endmodule
